### sv/fsp_pkg.sv
// Package: codes, character constants, result type and decode helpers of the format spec parser.
package fsp_pkg;

  localparam logic [7:0] ChPercent = 8'h25;
  localparam logic [7:0] ChDot     = 8'h2e;
  localparam logic [7:0] ChSpace   = 8'h20;
  localparam logic [7:0] ChHash    = 8'h23;
  localparam logic [7:0] ChZero    = 8'h30;
  localparam logic [7:0] ChNine    = 8'h39;
  localparam logic [7:0] ChMinus   = 8'h2d;
  localparam logic [7:0] ChPlus    = 8'h2b;
  localparam logic [7:0] ChLenL    = 8'h6c;
  localparam logic [7:0] ChLenH    = 8'h68;

  localparam logic [1:0] StStandard = 2'd0;
  localparam logic [1:0] StCustom   = 2'd1;
  localparam logic [1:0] StUnknown  = 2'd2;
  localparam logic [1:0] StNoPct    = 2'd3;

  localparam logic [1:0] LenNone = 2'd0;
  localparam logic [1:0] LenL    = 2'd1;
  localparam logic [1:0] LenH    = 2'd2;

  localparam logic [4:0] FlagSpace = 5'b00001;
  localparam logic [4:0] FlagHash  = 5'b00010;
  localparam logic [4:0] FlagZero  = 5'b00100;
  localparam logic [4:0] FlagMinus = 5'b01000;
  localparam logic [4:0] FlagPlus  = 5'b10000;
  localparam logic [4:0] FlagNone  = 5'b00000;

  typedef struct packed {
    logic [1:0]  status;
    logic [4:0]  flag_bits;
    logic [15:0] field_width;
    logic [15:0] precision_value;
    logic [1:0]  length_code;
    logic [7:0]  spec_char;
  } fsp_result_t;

  function automatic logic [4:0] flag_bit(input logic [7:0] c);
    logic [4:0] f;
    case (c)
      ChSpace: f = FlagSpace;
      ChHash:  f = FlagHash;
      ChZero:  f = FlagZero;
      ChMinus: f = FlagMinus;
      ChPlus:  f = FlagPlus;
      default: f = FlagNone;
    endcase
    return f;
  endfunction

  function automatic logic [1:0] len_code(input logic [7:0] c);
    logic [1:0] l;
    case (c)
      ChLenL:  l = LenL;
      ChLenH:  l = LenH;
      default: l = LenNone;
    endcase
    return l;
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= ChZero) && (c <= ChNine);
  endfunction

  function automatic logic is_std(input logic [7:0] c);
    logic r;
    case (c) inside
      8'h63, 8'h73, 8'h69, 8'h64, 8'h75, 8'h6f, 8'h78, 8'h58, 8'h70: r = 1'b1;
      default: r = 1'b0;
    endcase
    return r;
  endfunction

  function automatic logic is_custom(input logic [7:0] c);
    logic r;
    case (c) inside
      8'h72, 8'h52, 8'h53, 8'h62: r = 1'b1;
      default: r = 1'b0;
    endcase
    return r;
  endfunction

endpackage

### sv/fsp_if.sv
// Interfaces: character input channel and result output channel.
interface fsp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] ch;

  modport source (output valid, output ch, input ready);
  modport sink   (input valid, input ch, output ready);
endinterface

interface fsp_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic [4:0]  flag_bits;
  logic [15:0] field_width;
  logic [15:0] precision_value;
  logic [1:0]  length_code;
  logic [7:0]  spec_char;

  modport source (output valid, output status, output flag_bits, output field_width,
                  output precision_value, output length_code, output spec_char,
                  input ready);
  modport sink   (input valid, input status, input flag_bits, input field_width,
                  input precision_value, input length_code, input spec_char,
                  output ready);
endinterface

### sv/fsp_sat_mac.sv
// Saturating decimal accumulate: acc * 10 + digit, clamped at the all-ones value.
module fsp_sat_mac #(
  parameter int NUM_BITS = 16
) (
  input  logic [NUM_BITS-1:0] acc_i,
  input  logic [3:0]          digit_i,
  output logic [NUM_BITS-1:0] acc_o
);

  localparam int SumW = NUM_BITS + 4;

  logic [SumW-1:0] sum;
  logic [SumW-1:0] max_ext;

  assign sum     = {1'b0, acc_i, 3'b000} + {3'b000, acc_i, 1'b0} + SumW'(digit_i);
  assign max_ext = {4'b0000, {NUM_BITS{1'b1}}};
  assign acc_o   = (sum > max_ext) ? {NUM_BITS{1'b1}} : sum[NUM_BITS-1:0];

endmodule

### sv/fsp_out_reg.sv
// Result register: holds one result word until the sink takes it.
module fsp_out_reg (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                load_i,
  input  fsp_pkg::fsp_result_t res_i,
  output logic                free_o,
  fsp_out_if.source           out_o
);
  import fsp_pkg::*;

  logic        valid_q;
  fsp_result_t res_q;

  assign free_o = !valid_q || out_o.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (load_i) begin
      valid_q <= 1'b1;
    end else if (out_o.ready) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      res_q <= res_i;
    end
  end

  assign out_o.valid           = valid_q;
  assign out_o.status          = res_q.status;
  assign out_o.flag_bits       = res_q.flag_bits;
  assign out_o.field_width     = res_q.field_width;
  assign out_o.precision_value = res_q.precision_value;
  assign out_o.length_code     = res_q.length_code;
  assign out_o.spec_char       = res_q.spec_char;

endmodule

### sv/format_spec_parser.sv
// Top level: byte-serial parser for %[flags][width][.precision][l|h]specifier.
//
// Takes one character word per cycle when ready, and gives one result word
// when a specifier byte closes a specification, or at once for any byte other
// than '%' while idle. Every byte is handled in the cycle it is accepted: the
// parse phase and the flag, width, precision and length registers update at
// that edge, and a result lands in the output register, visible the next cycle.
// Input ready is high whenever the output register is empty or being drained,
// so the sustained rate is one character per cycle if the sink keeps up. Width
// and precision accumulate in NUM_BITS-bit registers with a multiply-by-ten
// add that saturates at 2^NUM_BITS - 1; the result fields carry the low 16 bits.
module format_spec_parser #(
  parameter int NUM_BITS = 16
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  fsp_in_if.sink    in_i,
  fsp_out_if.source out_o
);
  import fsp_pkg::*;

  typedef enum logic [4:0] {
    PH_IDLE  = 5'b00001,
    PH_FLAGS = 5'b00010,
    PH_WIDTH = 5'b00100,
    PH_PREC  = 5'b01000,
    PH_SPEC  = 5'b10000
  } phase_e;

  phase_e              phase_q, phase_d;
  logic [4:0]          flag_q, flag_d;
  logic [NUM_BITS-1:0] width_q, width_d;
  logic [NUM_BITS-1:0] prec_q, prec_d;
  logic [1:0]          len_q, len_d;

  logic [NUM_BITS-1:0] width_mac, prec_mac;
  logic [7:0]          c;
  logic [4:0]          fbit;
  logic [1:0]          lcode;
  logic                digit;
  logic                accept, free, res_valid;
  fsp_result_t         res, res_spec;

  assign c      = in_i.ch;
  assign fbit   = flag_bit(c);
  assign lcode  = len_code(c);
  assign digit  = is_digit(c);
  assign accept = in_i.valid && free;
  assign in_i.ready = free;

  fsp_sat_mac #(.NUM_BITS(NUM_BITS)) u_width_mac (
    .acc_i  (width_q),
    .digit_i(c[3:0]),
    .acc_o  (width_mac)
  );

  fsp_sat_mac #(.NUM_BITS(NUM_BITS)) u_prec_mac (
    .acc_i  (prec_q),
    .digit_i(c[3:0]),
    .acc_o  (prec_mac)
  );

  always_comb begin
    res_spec.flag_bits       = flag_q;
    res_spec.field_width     = 16'(width_q);
    res_spec.precision_value = 16'(prec_q);
    res_spec.length_code     = len_q;
    res_spec.spec_char       = c;
    if (is_std(c)) begin
      res_spec.status = StStandard;
    end else if (is_custom(c)) begin
      res_spec.status          = StCustom;
      res_spec.flag_bits       = FlagNone;
      res_spec.field_width     = 16'd0;
      res_spec.precision_value = 16'd0;
      res_spec.length_code     = LenNone;
    end else begin
      res_spec.status    = StUnknown;
      res_spec.spec_char = 8'd0;
    end
  end

  always_comb begin
    phase_d   = phase_q;
    flag_d    = flag_q;
    width_d   = width_q;
    prec_d    = prec_q;
    len_d     = len_q;
    res_valid = 1'b0;
    res       = res_spec;
    unique case (phase_q) inside
      PH_FLAGS, PH_WIDTH: begin
        if ((phase_q == PH_FLAGS) && (fbit != FlagNone)) begin
          flag_d = flag_q | fbit;
        end else if (digit) begin
          width_d = width_mac;
          phase_d = PH_WIDTH;
        end else if (c == ChDot) begin
          phase_d = PH_PREC;
        end else if (lcode != LenNone) begin
          len_d   = lcode;
          phase_d = PH_SPEC;
        end else begin
          res_valid = 1'b1;
        end
      end
      PH_PREC: begin
        if (digit) begin
          prec_d = prec_mac;
        end else if (lcode != LenNone) begin
          len_d   = lcode;
          phase_d = PH_SPEC;
        end else begin
          res_valid = 1'b1;
        end
      end
      PH_SPEC: begin
        res_valid = 1'b1;
      end
      default: begin
        flag_d  = FlagNone;
        width_d = '0;
        prec_d  = '0;
        len_d   = LenNone;
        if (c == ChPercent) begin
          phase_d = PH_FLAGS;
        end else begin
          phase_d                 = PH_IDLE;
          res_valid               = 1'b1;
          res.status              = StNoPct;
          res.flag_bits           = FlagNone;
          res.field_width         = 16'd0;
          res.precision_value     = 16'd0;
          res.length_code         = LenNone;
          res.spec_char           = 8'd0;
        end
      end
    endcase
    if (res_valid) begin
      phase_d = PH_IDLE;
      flag_d  = FlagNone;
      width_d = '0;
      prec_d  = '0;
      len_d   = LenNone;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_IDLE;
      flag_q  <= FlagNone;
      width_q <= '0;
      prec_q  <= '0;
      len_q   <= LenNone;
    end else if (accept) begin
      phase_q <= phase_d;
      flag_q  <= flag_d;
      width_q <= width_d;
      prec_q  <= prec_d;
      len_q   <= len_d;
    end
  end

  fsp_out_reg u_out_reg (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .load_i(accept && res_valid),
    .res_i (res),
    .free_o(free),
    .out_o (out_o)
  );

endmodule
